// ===== design/cdq_pkg.sv =====
// Shared types, codes and constants for the circular deque unit.
package cdq_pkg;

    // Default number of words held in the circular store
    localparam int CDQ_DEPTH = 128;

    // Field widths
    localparam int WORD_W   = 32;
    localparam int MODE_W   = 3;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 8;

    // Packed stream widths, padded to whole bytes
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 112;

    // Request codes
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_QUERY      = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic step;   // execute the request on the input bus
        logic fill;   // load the registered store read into the end cache
    } cdq_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic needs_read;   // request on the input bus is a pop that refetches an end
    } cdq_stat_t;

endpackage

// ===== design/cdq_ctrl.sv =====
// Controller state machine: input acceptance, store refetch sequencing, output valid.
module cdq_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  cdq_pkg::cdq_stat_t stat,
    output cdq_pkg::cdq_cmd_t  cmd
);
    import cdq_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_FILL = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    // Take a request only when the output register is free or emptying now
    assign s_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;

    // Next state and output valid
    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd.step       = 1'b0;
        cmd.fill       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.step = 1'b1;
                    if (stat.needs_read) begin
                        state_next = ST_FILL;
                    end else begin
                        out_valid_next = 1'b1;
                    end
                end
            end
            ST_FILL: begin
                cmd.fill       = 1'b1;
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The fill state always returns to idle on the next cycle
    a_fill_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FILL |=> state_reg == ST_IDLE)
        else $error("fill state held longer than one cycle");

    // A refetch always ends in a presented result
    a_fill_presents: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FILL |=> out_valid_reg)
        else $error("fill did not present a result");

    // No request is taken while a stalled result still occupies the output
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |-> !s_tready)
        else $error("request accepted over a stalled result");

endmodule

// ===== design/cdq_datapath.sv =====
// Datapath: end pointers, word count, circular store, end caches and result register.
module cdq_datapath #(
    parameter int DEPTH = cdq_pkg::CDQ_DEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  cdq_pkg::cdq_cmd_t             cmd,
    output cdq_pkg::cdq_stat_t            stat,
    input  logic [cdq_pkg::S_DATA_W-1:0]  s_tdata,
    output logic [cdq_pkg::M_DATA_W-1:0]  m_tdata
);
    import cdq_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);

    // Input fields
    logic        [MODE_W-1:0] mode;
    logic signed [WORD_W-1:0] value;
    assign mode  = s_tdata[MODE_W-1:0];
    assign value = s_tdata[MODE_W +: WORD_W];

    // State
    logic        [IDX_W-1:0]    head_reg, head_next;
    logic        [IDX_W-1:0]    tail_reg, tail_next;
    logic        [CNT_W-1:0]    cnt_reg, cnt_next;
    logic signed [WORD_W-1:0]   front_reg, front_next;
    logic signed [WORD_W-1:0]   back_reg, back_next;
    logic                       fill_front_reg, fill_front_next;
    logic        [STATUS_W-1:0] status_reg, status_next;
    logic signed [WORD_W-1:0]   popped_reg, popped_next;

    // Store
    logic signed [WORD_W-1:0] mem [DEPTH];
    logic signed [WORD_W-1:0] rd_data_reg;
    logic                     wr_en, rd_en;
    logic        [IDX_W-1:0]  wr_addr, rd_addr;

    // Request decode and neighbor indexes
    logic             is_push, is_pop, at_front, is_empty, is_full, pop_ok;
    logic [IDX_W-1:0] head_inc, head_dec, tail_inc, tail_dec;

    always_comb begin
        is_push  = 1'b0;
        is_pop   = 1'b0;
        at_front = 1'b0;
        unique case (mode)
            MODE_PUSH_FRONT: begin
                is_push  = 1'b1;
                at_front = 1'b1;
            end
            MODE_PUSH_BACK: begin
                is_push = 1'b1;
            end
            MODE_POP_FRONT: begin
                is_pop   = 1'b1;
                at_front = 1'b1;
            end
            MODE_POP_BACK: begin
                is_pop = 1'b1;
            end
            default: begin
                // query and unused codes leave state alone
            end
        endcase
    end

    assign is_empty = (cnt_reg == '0);
    assign is_full  = (cnt_reg == DEPTH_CNT);
    assign pop_ok   = is_pop && !is_empty;
    assign head_inc = (head_reg == LAST_IDX) ? '0 : head_reg + IDX_W'(1);
    assign head_dec = (head_reg == '0) ? LAST_IDX : head_reg - IDX_W'(1);
    assign tail_inc = (tail_reg == LAST_IDX) ? '0 : tail_reg + IDX_W'(1);
    assign tail_dec = (tail_reg == '0) ? LAST_IDX : tail_reg - IDX_W'(1);

    // A pop that leaves words behind refetches the new end word
    assign stat.needs_read = pop_ok && (cnt_reg != ONE_CNT);

    // Step execution
    always_comb begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        cnt_next        = cnt_reg;
        front_next      = front_reg;
        back_next       = back_reg;
        fill_front_next = fill_front_reg;
        status_next     = status_reg;
        popped_next     = popped_reg;
        wr_en           = 1'b0;
        wr_addr         = '0;
        rd_en           = 1'b0;
        rd_addr         = '0;

        if (cmd.step) begin
            status_next = STAT_DONE;
            popped_next = '0;
            if (is_push) begin
                if (is_full) begin
                    status_next = STAT_FULL;
                end else begin
                    wr_en    = 1'b1;
                    cnt_next = cnt_reg + ONE_CNT;
                    if (is_empty) begin
                        // first word sits at index zero and is both ends
                        head_next  = '0;
                        tail_next  = '0;
                        wr_addr    = '0;
                        front_next = value;
                        back_next  = value;
                    end else if (at_front) begin
                        head_next  = head_dec;
                        wr_addr    = head_dec;
                        front_next = value;
                    end else begin
                        tail_next = tail_inc;
                        wr_addr   = tail_inc;
                        back_next = value;
                    end
                end
            end else if (is_pop) begin
                if (is_empty) begin
                    status_next = STAT_EMPTY;
                end else begin
                    popped_next     = at_front ? front_reg : back_reg;
                    cnt_next        = cnt_reg - ONE_CNT;
                    fill_front_next = at_front;
                    if (cnt_reg == ONE_CNT) begin
                        // deque drains: pointers return to zero
                        head_next = '0;
                        tail_next = '0;
                    end else if (at_front) begin
                        head_next = head_inc;
                        rd_en     = 1'b1;
                        rd_addr   = head_inc;
                    end else begin
                        tail_next = tail_dec;
                        rd_en     = 1'b1;
                        rd_addr   = tail_dec;
                    end
                end
            end
        end

        // Load the refetched end word
        if (cmd.fill) begin
            if (fill_front_reg) begin
                front_next = rd_data_reg;
            end else begin
                back_next = rd_data_reg;
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        front_reg      <= front_next;
        back_reg       <= back_next;
        fill_front_reg <= fill_front_next;
        status_reg     <= status_next;
        popped_reg     <= popped_next;
    end

    // Circular store, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= value;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Result packing; ends read as zero when nothing is held
    logic [CNT_W+COUNT_W-1:0] cnt_ext;
    logic signed [WORD_W-1:0] front_out, back_out;
    assign cnt_ext   = {{COUNT_W{1'b0}}, cnt_reg};
    assign front_out = is_empty ? '0 : front_reg;
    assign back_out  = is_empty ? '0 : back_reg;
    assign m_tdata   = {5'b0, cnt_ext[COUNT_W-1:0], is_empty, back_out, front_out,
                        popped_reg, status_reg};

    // Count never exceeds capacity
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= DEPTH_CNT)
        else $error("word count above capacity");

    // Empty deque keeps both pointers at zero
    a_empty_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        is_empty |-> (head_reg == '0 && tail_reg == '0))
        else $error("pointers off zero while empty");

    // A single held word is both ends
    a_single_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == ONE_CNT |-> head_reg == tail_reg)
        else $error("head and tail differ with one word held");

endmodule

// ===== design/circular_deque_unit.sv =====
// Circular deque unit: a double-ended queue of signed words held in an on-chip store.
//
// Request stream (s_): one transfer carries a mode (push front, push back, pop front,
// pop back, query) and a word to push. Result stream (m_): one transfer per request
// with a status, the popped word, the front and back words after the request, an
// empty flag and the word count. Pushes to a full deque and pops from an empty deque
// leave the contents unchanged and report it in the status.
// Pushes, queries and pops that empty the deque or find it empty go straight to the
// output register; a pop that leaves words behind also passes through a fill state,
// since the new end word is refetched through the store's registered read port.
// No request is taken during the fill state. The result sits in an output register;
// a new request is taken in the same cycle the previous result transfers. While the
// receiver stalls, the result holds and s_tready stays low.
// Reset (aresetn low, synchronous) empties the deque and drops any pending result;
// store contents are not cleared and need no sweep.
module circular_deque_unit #(
    parameter int DEPTH = cdq_pkg::CDQ_DEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // request: [2:0] mode, [34:3] value, [39:35] zero
    input  logic [cdq_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // result: [1:0] status, [33:2] popped_value, [65:34] front_value,
    // [97:66] back_value, [98] is_empty, [106:99] count, [111:107] zero
    output logic [cdq_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready
);
    import cdq_pkg::*;

    cdq_cmd_t  cmd;
    cdq_stat_t stat;

    cdq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    cdq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .stat    (stat),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata)
    );

endmodule
